// File: hw/rtl/length_framed_xor_deframer_core_macros.svh
// Assertion macros for the length-framed XOR deframer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LENGTH_FRAMED_XOR_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_FRAMED_XOR_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFXD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFXD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/lfxd_pkg.sv
// Shared types and constants for the length-framed XOR deframer.
// No dependencies.
package lfxd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 16;

   localparam logic [BYTE_W-1:0] START_FLAG_RESET = 8'h23; // '#'

   typedef enum logic [0:0] {
      KIND_BODY = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_XOR_ERR  = 2'd1,
      STATUS_BAD_FLAG = 2'd2
   } status_type;

endpackage

// File: hw/rtl/lfxd_req_if.sv
// Request channel of the deframer: one received byte per request.
// Depends on lfxd_pkg.
interface lfxd_req_if import lfxd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/lfxd_rsp_if.sv
// Result channel of the deframer: body bytes and end-of-frame status.
// Depends on lfxd_pkg.
interface lfxd_rsp_if import lfxd_pkg::*; ();
   logic                valid;
   logic                ready;
   kind_type            item_kind;
   logic [BYTE_W-1:0]   body_byte;
   logic [BYTE_W-1:0]   frame_command;
   logic [LENGTH_W-1:0] frame_body_length;
   status_type          frame_status;

   modport source (output valid, output item_kind, output body_byte,
                   output frame_command, output frame_body_length,
                   output frame_status, input ready);
   modport sink   (input valid, input item_kind, input body_byte,
                   input frame_command, input frame_body_length,
                   input frame_status, output ready);
endinterface

// File: hw/rtl/length_framed_xor_deframer_core.sv
// Length-framed XOR deframer. Each request carries one received byte. A frame
// is HEADER_BYTES header bytes (two start flags, a command byte at
// COMMAND_OFFSET, a big-endian 16-bit body length at LENGTH_OFFSET), the body,
// then one check byte; all bytes from offset 2 through the check byte must XOR
// to zero. Body bytes come out one result each; every frame ends with one
// status result (ok, XOR error, bad start flag). Header bytes give no result,
// except that a bad start flag drops the frame at the end of its header and
// the deframer starts again at offset 0. Throughput is one request per clock:
// the frame state updates in the accepting cycle and the result lands in a
// single output register, so a request is taken whenever that register is
// empty or being drained in the same cycle. Results show in the next cycle.
// The user must write the start flag (csr_wdata, default '#') with csr_we
// only while the deframer is idle; the block does not enforce this.
// Depends on lfxd_pkg, lfxd_req_if, lfxd_rsp_if and the macros header.
`include "length_framed_xor_deframer_core_macros.svh"

module length_framed_xor_deframer_core import lfxd_pkg::*; #(
   parameter int HEADER_BYTES   = 24,
   parameter int COMMAND_OFFSET = 2,
   parameter int LENGTH_OFFSET  = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata,
   lfxd_req_if.sink          req_chan,
   lfxd_rsp_if.source        rsp_chan
);

   // Position counter must reach HEADER_BYTES + 65535.
   localparam int POS_W = $clog2(HEADER_BYTES + (1 << LENGTH_W));

   localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] CMD_POS   = POS_W'(COMMAND_OFFSET);
   localparam logic [POS_W-1:0] LEN_HI    = POS_W'(LENGTH_OFFSET);
   localparam logic [POS_W-1:0] LEN_LO    = POS_W'(LENGTH_OFFSET + 1);
   localparam logic [POS_W-1:0] FLAG_ENDS = POS_W'(2); // flags occupy 0 and 1

   // Configuration
   logic [BYTE_W-1:0]   start_flag_ff;

   // Frame state
   logic [POS_W-1:0]    pos_ff,   pos_in;
   logic [BYTE_W-1:0]   xor_ff,   xor_in;
   logic [BYTE_W-1:0]   cmd_ff,   cmd_in;
   logic [LENGTH_W-1:0] len_ff,   len_in;
   logic                flags_ok_ff, flags_ok_in;

   // Result register
   logic                rsp_valid_ff;
   kind_type            kind_ff,   kind_in;
   logic [BYTE_W-1:0]   body_ff,   body_in;
   logic [BYTE_W-1:0]   rcmd_ff;
   logic [LENGTH_W-1:0] rlen_ff;
   status_type          status_ff, status_in;

   logic                req_fire;
   logic                emit;
   logic [POS_W-1:0]    pos_inc;
   logic [POS_W-1:0]    frame_total;
   logic [BYTE_W-1:0]   rx;

   // Take a request whenever the result slot is free or drains this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;
   assign pos_inc        = pos_ff + POS_W'(1);
   assign frame_total    = HDR_POS + POS_W'(len_ff);

   always_comb begin
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      flags_ok_in = flags_ok_ff;
      emit        = 1'b0;
      kind_in     = KIND_BODY;
      body_in     = '0;
      status_in   = STATUS_OK;

      if (pos_ff < HDR_POS) begin
         // Header byte: fields are cleared at the start of each frame.
         if (pos_ff == '0) begin
            cmd_in = '0;
            len_in = '0;
         end
         if (pos_ff < FLAG_ENDS) begin
            if (rx != start_flag_ff) begin
               flags_ok_in = 1'b0;
            end
         end else begin
            xor_in = xor_ff ^ rx;
         end
         if (pos_ff == CMD_POS) begin
            cmd_in = rx;
         end
         if (pos_ff == LEN_HI) begin
            len_in = {rx, len_in[BYTE_W-1:0]};
         end
         if (pos_ff == LEN_LO) begin
            len_in = {len_in[LENGTH_W-1:BYTE_W], rx};
         end
         pos_in = pos_inc;
         // Bad start flag: report and drop once the header is complete.
         if (pos_inc == HDR_POS && !flags_ok_in) begin
            emit        = 1'b1;
            kind_in     = KIND_END;
            status_in   = STATUS_BAD_FLAG;
            pos_in      = '0;
            xor_in      = '0;
            flags_ok_in = 1'b1;
         end
      end else begin
         xor_in = xor_ff ^ rx;
         emit   = 1'b1;
         if (pos_ff < frame_total) begin
            // Body byte, forwarded as is.
            pos_in  = pos_inc;
            body_in = rx;
         end else begin
            // Check byte closes the frame.
            kind_in     = KIND_END;
            status_in   = (xor_in == '0) ? STATUS_OK : STATUS_XOR_ERR;
            pos_in      = '0;
            xor_in      = '0;
            flags_ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_flag_ff <= START_FLAG_RESET;
         pos_ff        <= '0;
         xor_ff        <= '0;
         cmd_ff        <= '0;
         len_ff        <= '0;
         flags_ok_ff   <= 1'b1;
      end else begin
         if (csr_we) begin
            start_flag_ff <= csr_wdata;
         end
         if (req_fire) begin
            pos_ff      <= pos_in;
            xor_ff      <= xor_in;
            cmd_ff      <= cmd_in;
            len_ff      <= len_in;
            flags_ok_ff <= flags_ok_in;
         end
      end
   end

   // Output slot: valid cleared under reset, payload loads only on a new result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= req_fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         kind_ff   <= kind_in;
         body_ff   <= body_in;
         rcmd_ff   <= cmd_in;
         rlen_ff   <= len_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.item_kind         = kind_ff;
   assign rsp_chan.body_byte         = body_ff;
   assign rsp_chan.frame_command     = rcmd_ff;
   assign rsp_chan.frame_body_length = rlen_ff;
   assign rsp_chan.frame_status      = status_ff;

   // A pending, stalled result must block new requests.
   `LFXD_ASSERT_NOW(a_no_overrun, clock, reset,
      rsp_valid_ff && !rsp_chan.ready, !req_chan.ready,
      "request taken while result stalled")

   // Every end-of-frame result restarts the frame at offset 0.
   `LFXD_ASSERT_NEXT(a_restart, clock, reset,
      req_fire && emit && kind_in == KIND_END, pos_ff == '0 && xor_ff == '0,
      "frame state not restarted after end of frame")

   // Frames with a bad start flag never reach the body.
   `LFXD_ASSERT_NOW(a_flags_in_body, clock, reset,
      pos_ff >= HDR_POS, flags_ok_ff,
      "body reached with bad start flag")

   // Body results always carry ok status.
   `LFXD_ASSERT_NOW(a_body_status, clock, reset,
      rsp_valid_ff && kind_ff == KIND_BODY, status_ff == STATUS_OK,
      "body result with nonzero status")

endmodule
